/* src/srdz_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdz_pkg: shared types and constants for the stick dead-zone unit
// Field widths, register map, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package srdz_pkg;

    localparam int IN_W            = 16;   // raw_x, raw_y
    localparam int CFG_W           = 16;   // dead_zone, active_threshold
    localparam int OUT_W           = 17;   // out_x, out_y
    localparam int MAG_W           = 16;   // magnitude
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MIN_RANGE       = 33;   // floor of the rescale divisor

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    localparam int ADDR_W      = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 16'd7864;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd16384;

    typedef enum logic {
        REG_DEAD_ZONE = 1'b0,
        REG_THRESHOLD = 1'b1
    } srdz_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_MAG,
        ST_MUL,
        ST_DIV,
        ST_OSQ,
        ST_FIN
    } srdz_state_t;

    typedef struct packed {
        logic release_res;
        logic trigger;
        logic press;
    } srdz_flags_t;

endpackage

/* src/stick_radial_deadzone_edge_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stick_radial_deadzone_edge_unit: radial dead zone and press edges, one stick
// Conditions one two-axis stick sample per request and flags activity edges.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes a request {raw_x, raw_y} with connected in s_tuser. The
//   m_ channel returns exactly one result per request: {out_x, out_y,
//   magnitude} and the press/trigger/release flags in m_tuser.
//   Work runs on bit-serial units: two shift-add multipliers, two restoring
//   dividers, a 16-bit multiplier for threshold^2 and a 2-bit-a-step root.
//   Each phase has a launch step, then one bit per cycle, then an exit step.
//   A disconnected or dead-zone sample skips the rescale divide and the axis
//   multiply/divide. One request is in flight at a time; the next one is
//   taken once the sequencer has returned to idle after the result is
//   registered.
//   The result sits in an output register; a new request is accepted while
//   it waits. If the receiver still holds the previous result when the next
//   one is ready, the sequencer waits in its final state.
//   Reset (aresetn low, synchronous) clears the sequencer, the result valid,
//   the stored activity bit and loads the register defaults.
//   APB: dead_zone at 0x0, active_threshold at 0x4, write only while idle.
// ----------------------------------------------------------------------------
module stick_radial_deadzone_edge_unit
    import srdz_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // raw_x [15:0], raw_y [31:16]
    input  logic                 s_tuser,   // connected [0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_x [16:0], out_y [33:17],
                                            // magnitude [49:34], zero [55:50]
    output logic [M_TUSER_W-1:0] m_tuser,   // press [0], trigger [1],
                                            // release_res [2]
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = 2 * SB;          // squares and products
    localparam int SQW   = 2 * SB + 1;      // sum of output squares
    localparam int CMPW  = 2 * CFG_W + 1;   // activity compare
    localparam int RT_W  = SB + 3;          // root trial width
    localparam int CW    = $clog2(SB + 1);
    localparam int ONE_I = 2 ** (SB - 1);

    localparam logic [SB-1:0]    ONE_V         = SB'(ONE_I);
    localparam logic [SB-1:0]    MAXPOS_V      = SB'(ONE_I - 1);
    localparam logic [SB-1:0]    HALF_V        = SB'((ONE_I - 1) / 2);
    localparam logic [SB-1:0]    RANGE_FLOOR_V = SB'(MIN_RANGE);
    localparam logic [CFG_W-1:0] DZ_LIMIT      = CFG_W'(ONE_I - MIN_RANGE);

    // sequencer
    srdz_state_t state_reg, state_next;
    logic        launch_reg, launch_next;
    logic        out_free;
    logic        load_out;

    // config
    logic        cfg_write;
    logic [CFG_W-1:0] dz_reg;
    logic [CFG_W-1:0] thr_reg;

    // sample
    logic [SB:0]   norm_x, norm_y;
    logic [SB-1:0] ax_reg, ay_reg;
    logic          sx_reg, sy_reg, conn_reg;

    // root
    logic [PW-1:0]   rad_reg;
    logic [PW-1:0]   rad_sum;
    logic [SB:0]     rem_reg;
    logic [SB-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic [RT_W-1:0] rt_shift, rt_trial, rt_diff;
    logic            rt_fits;

    // rescale
    logic          dz_skip;
    logic [SB-1:0] excess, range_v;
    logic          sat;
    logic [SB-1:0] mag_reg, qx_reg, qy_reg;

    // units
    logic          mul_start, div_start, thr_start;
    logic [SB-1:0] mul_xa, mul_xb, mul_ya, mul_yb;
    logic [SB-1:0] div_xr, div_xl, div_xd, div_yr, div_yl, div_yd;
    logic          mul_x_busy, mul_y_busy, mul_t_busy, div_x_busy, div_y_busy;
    logic [PW-1:0] mul_x_p, mul_y_p;
    logic [2*CFG_W-1:0] thr_p;
    logic [SB-1:0] div_x_q, div_y_q;
    logic          mul_busy, div_busy;

    // result
    logic [SQW-1:0]   sq_sum;
    logic             cur;
    logic [SB:0]      qx_ext, qy_ext, ox_val, oy_val;
    logic [OUT_W-1:0] out_x_reg, out_y_reg;
    logic [MAG_W-1:0] mag_out_reg;
    srdz_flags_t      flags_reg, flags_now;
    logic             m_tvalid_reg;
    logic             was_active_reg;

    // Positive readings stretch by ONE/(ONE-1), rounded half up; since the
    // reading never exceeds ONE-1 that is a single +1 step. Returns {sign, |v|}.
    function automatic logic [SB:0] norm_axis(input logic [SB-1:0] raw);
        logic bump;
        bump = ((raw + HALF_V) >= MAXPOS_V);
        return raw[SB-1] ? {1'b1, ~raw + 1'b1} : {1'b0, raw + SB'(bump)};
    endfunction

    assign norm_x = norm_axis(s_tdata[SB-1:0]);
    assign norm_y = norm_axis(s_tdata[IN_W+SB-1:IN_W]);

    // ---------------- root: two radicand bits per step ----------------
    assign rad_sum  = mul_x_p + mul_y_p;
    assign rt_shift = {rem_reg, rad_reg[PW-1:PW-2]};
    assign rt_trial = {1'b0, root_reg, 2'b01};
    assign rt_diff  = rt_shift - rt_trial;
    assign rt_fits  = (rt_shift >= rt_trial);

    // ---------------- rescale decisions ----------------
    assign dz_skip = !conn_reg || (CFG_W'(root_reg) <= dz_reg);
    assign excess  = root_reg - dz_reg[SB-1:0];
    assign range_v = (dz_reg > DZ_LIMIT) ? RANGE_FLOOR_V : ONE_V - dz_reg[SB-1:0];
    assign sat     = (excess >= range_v);

    assign mul_busy = mul_x_busy || mul_y_busy;
    assign div_busy = div_x_busy || div_y_busy;

    // ---------------- result assembly ----------------
    assign sq_sum = SQW'(mul_x_p) + SQW'(mul_y_p);
    assign cur    = (CMPW'(sq_sum) >= CMPW'(thr_p));
    assign qx_ext = {1'b0, qx_reg};
    assign qy_ext = {1'b0, qy_reg};
    assign ox_val = sx_reg ? (~qx_ext + 1'b1) : qx_ext;
    assign oy_val = sy_reg ? (~qy_ext + 1'b1) : qy_ext;

    assign flags_now.press       = cur;
    assign flags_now.trigger     = cur && !was_active_reg;
    assign flags_now.release_res = !cur && was_active_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SQ;
            end
            ST_SQ: begin
                if (!launch_reg && !mul_busy) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (!launch_reg && cnt_reg == '0) state_next = ST_MAG;
            end
            ST_MAG: begin
                if (launch_reg) begin
                    if (dz_skip) begin
                        state_next = ST_OSQ;
                    end else if (sat) begin
                        state_next = ST_MUL;
                    end
                end else if (!div_busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!launch_reg && !mul_busy) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!launch_reg && !div_busy) state_next = ST_OSQ;
            end
            ST_OSQ: begin
                if (!launch_reg && !mul_busy && !mul_t_busy) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign launch_next = (state_next != state_reg);

    // ---------------- sequencer outputs ----------------
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        load_out  = (state_reg == ST_FIN) && out_free;
        mul_start = launch_reg && (state_reg == ST_SQ || state_reg == ST_MUL ||
                                   state_reg == ST_OSQ);
        thr_start = launch_reg && (state_reg == ST_OSQ);
        div_start = launch_reg && ((state_reg == ST_MAG && !dz_skip && !sat) ||
                                   state_reg == ST_DIV);
        mul_xa = ax_reg;
        mul_xb = ax_reg;
        mul_ya = ay_reg;
        mul_yb = ay_reg;
        div_xr = SB'(mul_x_p[PW-2:SB]);
        div_xl = mul_x_p[SB-1:0];
        div_xd = root_reg;
        div_yr = SB'(mul_y_p[PW-2:SB]);
        div_yl = mul_y_p[SB-1:0];
        div_yd = root_reg;
        case (state_reg)
            ST_MUL: begin
                mul_xb = mag_reg;
                mul_yb = mag_reg;
            end
            ST_OSQ: begin
                mul_xa = qx_reg;
                mul_xb = qx_reg;
                mul_ya = qy_reg;
                mul_yb = qy_reg;
            end
            ST_MAG: begin
                // fraction divide: excess * 2^SB / range, halved on capture
                div_xr = excess;
                div_xl = '0;
                div_xd = range_v;
            end
            default: begin
            end
        endcase
    end

    // ---------------- bit-serial units ----------------
    srdz_mul #(.WIDTH(SB)) u_mul_x (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_xa), .b(mul_xb), .busy(mul_x_busy), .product(mul_x_p)
    );

    srdz_mul #(.WIDTH(SB)) u_mul_y (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_ya), .b(mul_yb), .busy(mul_y_busy), .product(mul_y_p)
    );

    srdz_mul #(.WIDTH(CFG_W)) u_mul_thr (
        .aclk(aclk), .aresetn(aresetn), .start(thr_start),
        .a(thr_reg), .b(thr_reg), .busy(mul_t_busy), .product(thr_p)
    );

    srdz_div #(.WIDTH(SB)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .rem_init(div_xr), .lo_init(div_xl), .divisor(div_xd),
        .busy(div_x_busy), .quotient(div_x_q)
    );

    // y divider only runs in the axis phase; its start is gated off in the mag phase
    srdz_div #(.WIDTH(SB)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(div_start && state_reg == ST_DIV),
        .rem_init(div_yr), .lo_init(div_yl), .divisor(div_yd),
        .busy(div_y_busy), .quotient(div_y_q)
    );

    // ---------------- config port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (srdz_reg_t'(paddr[REG_IDX_LSB]))
            REG_DEAD_ZONE: prdata = PDATA_W'(dz_reg);
            REG_THRESHOLD: prdata = PDATA_W'(thr_reg);
            default:       prdata = '0;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            was_active_reg <= 1'b0;
            dz_reg         <= DEAD_ZONE_RST;
            thr_reg        <= THRESHOLD_RST;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (state_reg == ST_ROOT) begin
                if (launch_reg) begin
                    cnt_reg <= CW'(SB);
                end else if (cnt_reg != '0) begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            if (load_out) begin
                m_tvalid_reg   <= 1'b1;
                was_active_reg <= cur;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_write) begin
                case (srdz_reg_t'(paddr[REG_IDX_LSB]))
                    REG_DEAD_ZONE: dz_reg  <= pwdata[CFG_W-1:0];
                    REG_THRESHOLD: thr_reg <= pwdata[CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ax_reg   <= norm_x[SB-1:0];
            sx_reg   <= norm_x[SB];
            ay_reg   <= norm_y[SB-1:0];
            sy_reg   <= norm_y[SB];
            conn_reg <= s_tuser;
        end
        if (state_reg == ST_ROOT) begin
            if (launch_reg) begin
                rad_reg  <= rad_sum;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (cnt_reg != '0) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rt_fits ? rt_diff[SB:0] : rt_shift[SB:0];
                root_reg <= {root_reg[SB-2:0], rt_fits};
            end
        end
        if (state_reg == ST_MAG) begin
            if (launch_reg) begin
                if (dz_skip) begin
                    mag_reg <= '0;
                    qx_reg  <= '0;
                    qy_reg  <= '0;
                end else if (sat) begin
                    mag_reg <= ONE_V;
                end
            end else if (!div_busy) begin
                mag_reg <= {1'b0, div_x_q[SB-1:1]};
            end
        end
        if (state_reg == ST_DIV && !launch_reg && !div_busy) begin
            qx_reg <= div_x_q;
            qy_reg <= div_y_q;
        end
        if (load_out) begin
            out_x_reg   <= OUT_W'($signed(ox_val));
            out_y_reg   <= OUT_W'($signed(oy_val));
            mag_out_reg <= MAG_W'(mag_reg);
            flags_reg   <= flags_now;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({mag_out_reg, out_y_reg, out_x_reg});
    assign m_tuser  = flags_reg;

    // ---------------- assertions ----------------
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(mul_x_busy || mul_y_busy || mul_t_busy || div_x_busy || div_y_busy))
        else $error("serial unit still busy while taking a request");

    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (mag_out_reg <= MAG_W'(ONE_I)))
        else $error("magnitude above full scale");

    a_edge_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(flags_reg.trigger && flags_reg.release_res))
        else $error("trigger and release on the same result");

    a_trig_press: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && flags_reg.trigger) |-> flags_reg.press)
        else $error("trigger without press");

    a_state_track: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (m_tvalid_reg && (flags_reg.press == was_active_reg)))
        else $error("stored activity does not match the delivered press");

endmodule

/* src/srdz_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdz_mul: bit-serial unsigned multiplier
// Shift-add over the bits of b, LSB first, one bit per cycle.
// ----------------------------------------------------------------------------
module srdz_mul
    import srdz_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic               busy,
    output logic [2*WIDTH-1:0] product
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] hi_reg;
    logic [WIDTH-1:0] lo_reg;
    logic [WIDTH:0]   sum;

    assign busy    = (cnt_reg != '0);
    assign sum     = {1'b0, hi_reg} + ({(WIDTH + 1){lo_reg[0]}} & {1'b0, a_reg});
    assign product = {hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(WIDTH);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg  <= a;
            lo_reg <= b;
            hi_reg <= '0;
        end else if (busy) begin
            hi_reg <= sum[WIDTH:1];
            lo_reg <= {sum[0], lo_reg[WIDTH-1:1]};
        end
    end

endmodule

/* src/srdz_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srdz_div: bit-serial restoring divider
// Partial remainder rem_init must be below divisor; one quotient bit a cycle.
// ----------------------------------------------------------------------------
module srdz_div
    import srdz_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] rem_init,
    input  logic [WIDTH-1:0] lo_init,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] lo_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign busy     = (cnt_reg != '0);
    assign trial    = {rem_reg, lo_reg[WIDTH-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign fits     = (trial >= {1'b0, d_reg});
    assign quotient = lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(WIDTH);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= rem_init;
            lo_reg  <= lo_init;
            d_reg   <= divisor;
        end else if (busy) begin
            rem_reg <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            lo_reg  <= {lo_reg[WIDTH-2:0], fits};
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for stick_radial_deadzone_edge_unit
// Streams stick samples through the unit under bursty input and a stalling
// output, and predicts every result in a scoreboard with its own copy of the
// dead zone, threshold and activity bit. Registers are rewritten between
// phases to cover the extremes.
// ----------------------------------------------------------------------------
import srdz_pkg::*;

localparam longint FULL_SCALE = longint'(1) << (SAMPLE_BITS_DEF - 1);

class stick_scoreboard;
    typedef struct {
        logic signed [OUT_W-1:0] out_x;
        logic signed [OUT_W-1:0] out_y;
        logic [MAG_W-1:0]        magnitude;
        srdz_flags_t             flags;
    } stick_result_t;

    logic [CFG_W-1:0] dead_zone;
    logic [CFG_W-1:0] threshold;
    bit               was_active;
    stick_result_t    expected_sticks[$];
    int               failures;

    function new();
        dead_zone  = DEAD_ZONE_RST;
        threshold  = THRESHOLD_RST;
        was_active = 1'b0;
        failures   = 0;
    endfunction

    function void set_reg(srdz_reg_t idx, logic [PDATA_W-1:0] value);
        if (idx == REG_DEAD_ZONE)
            dead_zone = value[CFG_W-1:0];
        else
            threshold = value[CFG_W-1:0];
    endfunction

    // floor square root, one result bit per pass
    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = longint'(1) << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // positive readings stretch to full scale, rounded half up
    function longint scale_axis(logic signed [IN_W-1:0] raw);
        longint v;
        longint top;
        v   = longint'(raw);
        top = FULL_SCALE - 1;
        if (v <= 0)
            return v;
        return (v * FULL_SCALE + top / 2) / top;
    endfunction

    function void condition_sample(logic signed [IN_W-1:0] raw_x,
                                   logic signed [IN_W-1:0] raw_y, logic connected);
        longint        x, y, len, span, excess, mag, ox, oy, sq, thr2;
        bit            active;
        stick_result_t r;
        x   = scale_axis(raw_x);
        y   = scale_axis(raw_y);
        len = longint'(int_sqrt(longint'(x * x + y * y)));
        mag = 0;
        ox  = 0;
        oy  = 0;
        if (connected && len > longint'(dead_zone)) begin
            span   = FULL_SCALE - longint'(dead_zone);
            excess = len - longint'(dead_zone);
            if (span < MIN_RANGE)
                span = MIN_RANGE;
            mag = excess * FULL_SCALE / span;
            if (mag > FULL_SCALE)
                mag = FULL_SCALE;
            ox = x * mag / len;
            oy = y * mag / len;
        end
        sq     = ox * ox + oy * oy;
        thr2   = longint'(threshold) * longint'(threshold);
        active = (sq >= thr2);
        r.out_x             = ox[OUT_W-1:0];
        r.out_y             = oy[OUT_W-1:0];
        r.magnitude         = mag[MAG_W-1:0];
        r.flags.press       = active;
        r.flags.trigger     = active && !was_active;
        r.flags.release_res = !active && was_active;
        was_active = active;
        expected_sticks.insert(expected_sticks.size(), r);
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
        stick_result_t                           want;
        logic signed [OUT_W-1:0]                 got_x, got_y;
        logic [MAG_W-1:0]                        got_mag;
        logic [M_TDATA_W-2*OUT_W-MAG_W-1:0]      got_pad;
        srdz_flags_t                             got_flags;
        {got_pad, got_mag, got_y, got_x} = tdata;
        got_flags = srdz_flags_t'(tuser);
        if (expected_sticks.size() == 0) begin
            $error("result with no request outstanding: tdata %h tuser %b", tdata, tuser);
            failures++;
            return;
        end
        want = expected_sticks.pop_front();
        compare_field("out_x", 32'(want.out_x), 32'(got_x));
        compare_field("out_y", 32'(want.out_y), 32'(got_y));
        compare_field("magnitude", 32'(want.magnitude), 32'(got_mag));
        compare_field("tdata pad", 0, 32'(got_pad));
        compare_field("press", 32'(want.flags.press), 32'(got_flags.press));
        compare_field("trigger", 32'(want.flags.trigger), 32'(got_flags.trigger));
        compare_field("release_res", 32'(want.flags.release_res),
                      32'(got_flags.release_res));
    endfunction
endclass

module tb;

    // generous: ~1150 requests plus gaps, stalls and the long hold
    localparam int RUN_LIMIT    = 2_000_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 95;
    localparam int LONG_HOLD    = 800;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // raw_x [15:0], raw_y [31:16]
    logic                 s_tuser  = 1'b0;  // connected [0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // out_x [16:0], out_y [33:17],
                                            // magnitude [49:34], zero [55:50]
    logic [M_TUSER_W-1:0] m_tuser;          // press [0], trigger [1], release_res [2]
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    stick_scoreboard sb = new();

    int  burst_left = 0;
    int  cycle_count = 0;

    // receiver state: stall pattern, long hold, handshakes seen
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  hold_left = 0;
    int  results_taken = 0;
    bit  long_hold_done = 1'b0;

    logic signed [IN_W-1:0] corners [5] = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

    stick_radial_deadzone_edge_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $error("run exceeded %0d cycles", RUN_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // Monitor. Both channels are sampled at the edge, before any update that
    // the edge itself causes. Requests are predicted in acceptance order, so
    // the activity bit in the scoreboard follows the unit's own.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.condition_sample(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W], s_tuser);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // Receiver. Switches between always-ready, coin-flip and mostly-stalled
    // stretches. Once, after a few hundred results and while a request is on
    // offer, it holds off for a long stretch so the output register and the
    // sequencer back up into s_tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            results_taken++;
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(20, 300);
        end else begin
            rx_mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_taken >= 300 && s_tvalid) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                default: m_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Offer one request. Requests come in bursts; between bursts valid drops
    // for a random gap, short or long enough to land on any phase of the
    // unit's sequence. A zero gap keeps valid high across bursts.
    task automatic offer_sample(input logic signed [IN_W-1:0] rx,
                                input logic signed [IN_W-1:0] ry, input logic conn);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(60, 140);
                default: gap = $urandom_range(1, 20);
            endcase
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ry, rx};
        s_tuser  <= conn;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Stop offering and wait until every predicted result has been checked.
    // The first edge lets the monitor record the last accepted request.
    task automatic drain_requests();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (sb.expected_sticks.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic check_reg(input srdz_reg_t idx, input logic [CFG_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(int'(idx) << REG_IDX_LSB);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== PDATA_W'(want)) begin
            $error("%s readback mismatch: expected %0d, got %0d", idx.name(), want, prdata);
            sb.failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // setup cycle, access cycle; the register takes the value at the access edge
    task automatic write_reg(input srdz_reg_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) << REG_IDX_LSB);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        check_reg(idx, value[CFG_W-1:0]);
    endtask

    // Random sample: full-range noise, corner values, small deflections that
    // bring the stick back to rest, and radii right on the dead-zone edge or
    // on the length that rescales to the activity threshold.
    task automatic random_stick(output logic signed [IN_W-1:0] rx,
                                output logic signed [IN_W-1:0] ry, output logic conn);
        int          pick;
        longint      span, ring;
        logic signed [IN_W-1:0] swap;
        pick = $urandom_range(0, 99);
        conn = ($urandom_range(0, 9) != 0);
        if (pick < 35) begin
            rx = IN_W'($urandom);
            ry = IN_W'($urandom);
        end else if (pick < 50) begin
            rx = corners[$urandom_range(0, 4)];
            ry = corners[$urandom_range(0, 4)];
        end else if (pick < 65) begin
            rx = IN_W'(int'($urandom_range(0, 4095)) - 2048);
            ry = IN_W'(int'($urandom_range(0, 4095)) - 2048);
        end else begin
            span = FULL_SCALE - longint'(sb.dead_zone);
            if (span < MIN_RANGE)
                span = MIN_RANGE;
            if (pick < 82)
                ring = longint'(sb.dead_zone);
            else
                ring = longint'(sb.dead_zone) + longint'(sb.threshold) * span / FULL_SCALE;
            ring = ring + int'($urandom_range(0, 8)) - 4;
            if (ring < 0)
                ring = 0;
            if (ring > FULL_SCALE - 1)
                ring = FULL_SCALE - 1;
            if ($urandom_range(0, 1) == 1) begin
                rx = IN_W'(ring);
                ry = IN_W'(int'($urandom_range(0, 6)) - 3);
            end else begin
                // roughly 45 degrees
                rx = IN_W'((ring * 46341) >>> 16);
                ry = IN_W'(rx + int'($urandom_range(0, 2)) - 1);
            end
            if ($urandom_range(0, 1) == 1)
                rx = -rx;
            if ($urandom_range(0, 1) == 1)
                ry = -ry;
            if ($urandom_range(0, 1) == 1) begin
                swap = rx;
                rx   = ry;
                ry   = swap;
            end
        end
    endtask

    // Directed requests at reset settings (dead zone 7864, threshold 16384):
    // full-scale corners, axes, the dead-zone edge from both signs, lengths
    // around the threshold, disconnected pads, and toggles for every edge.
    logic signed [IN_W-1:0] dir_x [24] = '{
        16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
        16'sd0, 16'sd7864, 16'sd7865, -16'sd7864, -16'sd7865, 16'sd0,
        16'sd1, -16'sd1, -16'sd20315, -16'sd20316, -16'sd20317, -16'sd20316,
        16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767};
    logic signed [IN_W-1:0] dir_y [24] = '{
        16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd0,
        -16'sd32768, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7863,
        16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
        16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd0, -16'sd32768};
    logic dir_conn [24] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    initial begin
        logic signed [IN_W-1:0] rx, ry;
        logic                   conn;
        logic [CFG_W-1:0]       dz, thr, junk;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_reg(REG_DEAD_ZONE, DEAD_ZONE_RST);
        check_reg(REG_THRESHOLD, THRESHOLD_RST);

        for (int i = 0; i < 24; i++)
            offer_sample(dir_x[i], dir_y[i], dir_conn[i]);
        drain_requests();

        // Each phase: new settings while idle, a block of random requests,
        // then a full drain before the next write.
        for (int phase = 0; phase < PHASES; phase++) begin
            junk = '0;
            case (phase)
                0: begin dz = 16'd0;     thr = 16'd0;     end  // everything active
                1: begin dz = 16'd32768; thr = 16'd32768; end  // divisor floor
                2: begin dz = 16'd32767; thr = 16'd16384; end
                3: begin dz = 16'd32735; thr = 16'd1;     end  // range exactly at floor
                4: begin dz = 16'd32740; thr = 16'd30000; end
                5: begin dz = 16'd0;     thr = 16'd32768; end
                6: begin dz = 16'd16384; thr = 16'd8192;  junk = 16'hA5C3; end
                7: begin dz = 16'hFFFF;  thr = 16'hFFFF;  end  // never active
                8: begin dz = DEAD_ZONE_RST; thr = THRESHOLD_RST; end
                default: begin
                    dz  = CFG_W'($urandom_range(0, 32768));
                    thr = CFG_W'($urandom_range(0, 32768));
                end
            endcase
            write_reg(REG_DEAD_ZONE, {junk, dz});
            write_reg(REG_THRESHOLD, {junk, thr});
            repeat (PHASE_ITEMS) begin
                random_stick(rx, ry, conn);
                offer_sample(rx, ry, conn);
            end
            drain_requests();
        end

        // catch any stray result after the last expected one
        repeat (150) @(posedge aclk);
        if (sb.failures == 0 && sb.expected_sticks.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
